### src/fixed_width_decimal_formatter_unit_defines.svh
`ifndef FIXED_WIDTH_DECIMAL_FORMATTER_UNIT_DEFINES_SVH
`define FIXED_WIDTH_DECIMAL_FORMATTER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FWDF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fwdf assertion failed");

// next-cycle implication, checked outside reset
`define FWDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fwdf assertion failed");

`endif

### src/fwdf_pkg.sv
package fwdf_pkg;

   localparam int MAG_BITS           = 32;
   localparam int CNT_W              = $clog2(MAG_BITS);
   localparam int BCD_DIGITS         = 10;
   localparam int DEFAULT_MAX_DIGITS = 10;
   localparam int STEP_W             = 2;

   localparam logic [5:0] CH_SPACE = 6'd32;
   localparam logic [5:0] CH_MINUS = 6'd45;
   localparam logic [5:0] CH_ZERO  = 6'd48;

   localparam logic [7:0] ADV_SMALL   = 8'd6;
   localparam logic [7:0] ADV_LARGE   = 8'd8;
   localparam logic [7:0] PITCH_SMALL = 8'd4;
   localparam logic [7:0] PITCH_LARGE = 8'd8;

   typedef enum logic [1:0] {
      COND_NO_START  = 2'd0,
      COND_CONV_MORE = 2'd1,
      COND_LEN_ZERO  = 2'd2,
      COND_IDX_MORE  = 2'd3
   } cond_type;

   typedef struct packed {
      logic              wait_start;
      logic              convert;
      logic              emit_sign;
      logic              emit_digit;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ucode_word_type;

   typedef struct packed {
      logic load;
      logic convert;
      logic emit_sign;
      logic emit_digit;
   } ctrl_type;

   typedef struct packed {
      logic conv_more;
      logic len_zero;
      logic idx_more;
   } status_type;

   localparam logic [STEP_W-1:0] STEP_IDLE  = 2'd0;
   localparam logic [STEP_W-1:0] STEP_CONV  = 2'd1;
   localparam logic [STEP_W-1:0] STEP_SIGN  = 2'd2;
   localparam logic [STEP_W-1:0] STEP_DIGIT = 2'd3;

   // jump to target when the condition holds, else fall through (wraps to idle)
   function automatic ucode_word_type ucode(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      w = '0;
      unique case (step)
         STEP_IDLE: begin
            w.wait_start = 1'b1;
            w.cond       = COND_NO_START;
            w.target     = STEP_IDLE;
         end
         STEP_CONV: begin
            w.convert = 1'b1;
            w.cond    = COND_CONV_MORE;
            w.target  = STEP_CONV;
         end
         STEP_SIGN: begin
            w.emit_sign = 1'b1;
            w.cond      = COND_LEN_ZERO;
            w.target    = STEP_IDLE;
         end
         STEP_DIGIT: begin
            w.emit_digit = 1'b1;
            w.cond       = COND_IDX_MORE;
            w.target     = STEP_DIGIT;
         end
      endcase
      return w;
   endfunction

endpackage

### src/fixed_width_decimal_formatter_unit.sv
// sequence: after the start beat the conversion loop runs, then the sign step registers a
// minus beat for a negative number, then the digit loop registers one character beat per cycle
// a new number is taken only once the sequencer is back in idle, after the 32-step
// bit-serial conversion loop, the sign step and the one-character-per-cycle emit loop
// results are strobed for one cycle each; the receiver cannot stall
// synchronous active-high reset returns the sequencer to idle and large_font to 0
module fixed_width_decimal_formatter_unit #(
   parameter int MAX_DIGITS = fwdf_pkg::DEFAULT_MAX_DIGITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_value,
   input  logic [3:0]         req_digit_count,
   input  logic [7:0]         req_start_column,
   input  logic [5:0]         req_start_row,
   input  logic               csr_write_enable,
   input  logic               csr_write_data,
   output logic               rsp_valid,
   output logic [5:0]         rsp_char_code,
   output logic [7:0]         rsp_column,
   output logic [5:0]         rsp_row,
   output logic               rsp_last
);

   `include "fixed_width_decimal_formatter_unit_defines.svh"

   fwdf_pkg::ctrl_type   ctrl;
   fwdf_pkg::status_type status;

   fwdf_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   fwdf_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .status           (status),
      .req_value        (req_value),
      .req_digit_count  (req_digit_count),
      .req_start_column (req_start_column),
      .req_start_row    (req_start_row),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_char_code    (rsp_char_code),
      .rsp_column       (rsp_column),
      .rsp_row          (rsp_row),
      .rsp_last         (rsp_last)
   );

   // a start beat always begins the conversion loop
   `FWDF_ASSERT_NEXT(a_start_goes_busy, clock, reset, start && !busy, busy)
   // a beat seen once the sequencer is idle again closes its number
   `FWDF_ASSERT_NOW(a_idle_beat_is_last, clock, reset, rsp_valid && !busy, rsp_last)
   // no beat directly follows the last one of a number
   `FWDF_ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_valid && rsp_last, !rsp_valid)

endmodule

### src/fwdf_sequencer.sv
module fwdf_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  fwdf_pkg::status_type status,
   output fwdf_pkg::ctrl_type   ctrl,
   output logic                 busy
);

   logic [fwdf_pkg::STEP_W-1:0] pc_ff, pc_in;
   fwdf_pkg::ucode_word_type    word;
   logic                        cond_hit;

   assign word = fwdf_pkg::ucode(pc_ff);

   always_comb begin
      unique case (word.cond)
         fwdf_pkg::COND_NO_START:  cond_hit = ~start;
         fwdf_pkg::COND_CONV_MORE: cond_hit = status.conv_more;
         fwdf_pkg::COND_LEN_ZERO:  cond_hit = status.len_zero;
         fwdf_pkg::COND_IDX_MORE:  cond_hit = status.idx_more;
         default:                  cond_hit = 1'b0;
      endcase
      pc_in = cond_hit ? word.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= fwdf_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.load       = word.wait_start & start;
   assign ctrl.convert    = word.convert;
   assign ctrl.emit_sign  = word.emit_sign;
   assign ctrl.emit_digit = word.emit_digit;
   assign busy            = ~word.wait_start;

endmodule

### src/fwdf_datapath.sv
module fwdf_datapath #(
   parameter int MAX_DIGITS = fwdf_pkg::DEFAULT_MAX_DIGITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fwdf_pkg::ctrl_type   ctrl,
   output fwdf_pkg::status_type status,
   input  logic signed [31:0]   req_value,
   input  logic [3:0]           req_digit_count,
   input  logic [7:0]           req_start_column,
   input  logic [5:0]           req_start_row,
   input  logic                 csr_write_enable,
   input  logic                 csr_write_data,
   output logic                 rsp_valid,
   output logic [5:0]           rsp_char_code,
   output logic [7:0]           rsp_column,
   output logic [5:0]           rsp_row,
   output logic                 rsp_last
);

   localparam int LEN_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   logic [fwdf_pkg::MAG_BITS-1:0] mag_ff, mag_in;
   logic [3:0]                    bcd_ff [fwdf_pkg::BCD_DIGITS];
   logic [3:0]                    bcd_in [fwdf_pkg::BCD_DIGITS];
   logic [3:0]                    adj    [fwdf_pkg::BCD_DIGITS];
   logic [fwdf_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic                          neg_ff, neg_in;
   logic [LEN_W-1:0]              len_ff, len_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [7:0]                    col_ff, col_in;
   logic [5:0]                    row_ff, row_in;
   logic                          shown_ff, shown_in;
   logic                          large_font_ff, large_font_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [5:0]                    rsp_code_ff, rsp_code_in;
   logic [7:0]                    rsp_col_ff, rsp_col_in;
   logic [5:0]                    rsp_row_ff, rsp_row_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic [3:0]                    cur_digit;
   logic                          blank;

   assign cur_digit = bcd_ff[idx_ff];
   assign blank     = ~shown_ff && (idx_ff != '0) && (cur_digit == 4'd0);

   // double dabble correction per digit
   always_comb begin
      for (int i = 0; i < fwdf_pkg::BCD_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   always_comb begin
      mag_in        = mag_ff;
      bcd_in        = bcd_ff;
      cnt_in        = cnt_ff;
      neg_in        = neg_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      shown_in      = shown_ff;
      large_font_in = csr_write_enable ? csr_write_data : large_font_ff;
      rsp_valid_in  = 1'b0;
      rsp_code_in   = rsp_code_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_last_in   = rsp_last_ff;

      if (ctrl.load) begin
         neg_in   = req_value[31];
         mag_in   = req_value[31] ? 32'(-req_value) : 32'(req_value);
         for (int i = 0; i < fwdf_pkg::BCD_DIGITS; i++) begin
            bcd_in[i] = 4'd0;
         end
         cnt_in   = '0;
         len_in   = (req_digit_count > 4'(MAX_DIGITS)) ? LEN_W'(MAX_DIGITS)
                                                       : LEN_W'(req_digit_count);
         col_in   = req_start_column;
         row_in   = req_start_row;
         shown_in = 1'b0;
      end

      if (ctrl.convert) begin
         bcd_in[0] = {adj[0][2:0], mag_ff[fwdf_pkg::MAG_BITS-1]};
         for (int i = 1; i < fwdf_pkg::BCD_DIGITS; i++) begin
            bcd_in[i] = {adj[i][2:0], adj[i-1][3]};
         end
         mag_in = {mag_ff[fwdf_pkg::MAG_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
      end

      if (ctrl.emit_sign) begin
         idx_in = IDX_W'(len_ff - 1'b1);
         if (neg_ff) begin
            rsp_valid_in = 1'b1;
            rsp_code_in  = fwdf_pkg::CH_MINUS;
            rsp_col_in   = col_ff;
            rsp_row_in   = row_ff;
            rsp_last_in  = (len_ff == '0);
            col_in       = col_ff + (large_font_ff ? fwdf_pkg::ADV_LARGE
                                                   : fwdf_pkg::ADV_SMALL);
         end
      end

      if (ctrl.emit_digit) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = blank ? fwdf_pkg::CH_SPACE : fwdf_pkg::CH_ZERO + 6'(cur_digit);
         rsp_col_in   = col_ff;
         rsp_row_in   = row_ff;
         rsp_last_in  = (idx_ff == '0);
         shown_in     = shown_ff | ~blank;
         col_in       = col_ff + (large_font_ff ? fwdf_pkg::PITCH_LARGE
                                                : fwdf_pkg::PITCH_SMALL);
         idx_in       = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         large_font_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         large_font_ff <= large_font_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      shown_ff    <= shown_in;
      rsp_code_ff <= rsp_code_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.conv_more = (cnt_ff != fwdf_pkg::CNT_W'(fwdf_pkg::MAG_BITS - 1));
   assign status.len_zero  = (len_ff == '0);
   assign status.idx_more  = (idx_ff != '0);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_code_ff;
   assign rsp_column    = rsp_col_ff;
   assign rsp_row       = rsp_row_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

### tb/fixed_width_decimal_formatter_unit_test.sv
`timescale 1ns / 100ps

module fixed_width_decimal_formatter_unit_test;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLES = 60;

   typedef struct packed {
      logic [5:0] char_code;
      logic [7:0] column;
      logic [5:0] row;
      logic       last;
   } screen_char_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_value;
   logic [3:0]         req_digit_count;
   logic [7:0]         req_start_column;
   logic [5:0]         req_start_row;
   logic               csr_write_enable;
   logic               csr_write_data;
   logic               rsp_valid;
   logic [5:0]         rsp_char_code;
   logic [7:0]         rsp_column;
   logic [5:0]         rsp_row;
   logic               rsp_last;

   screen_char_type expected_chars[$];
   screen_char_type oldest_char;
   logic            font_large;
   int              error_count = 0;
   int              cycle_count = 0;

   fixed_width_decimal_formatter_unit uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_digit_count  (req_digit_count),
      .req_start_column (req_start_column),
      .req_start_row    (req_start_row),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_char_code    (rsp_char_code),
      .rsp_column       (rsp_column),
      .rsp_row          (rsp_row),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // characters the block should put on screen for one number
   task automatic predict_number(input logic [31:0] value, input logic [3:0] count,
                                 input logic [7:0] col0, input logic [5:0] row);
      screen_char_type line[11];
      logic [31:0]     mag;
      logic [3:0]      digits[10];
      logic [7:0]      col;
      logic [7:0]      pitch;
      logic [5:0]      code;
      logic            shown;
      int              n;
      int              k;
      mag   = value[31] ? (32'd0 - value) : value;
      n     = (count > 10) ? 10 : int'(count);
      col   = col0;
      pitch = font_large ? fwdf_pkg::PITCH_LARGE : fwdf_pkg::PITCH_SMALL;
      shown = 1'b0;
      k     = 0;
      if (value[31]) begin
         line[k] = '{char_code: fwdf_pkg::CH_MINUS, column: col, row: row, last: 1'b0};
         k++;
         col = col + (font_large ? fwdf_pkg::ADV_LARGE : fwdf_pkg::ADV_SMALL);
      end
      for (int i = 0; i < 10; i++) begin
         digits[i] = 4'(mag % 10);
         mag       = mag / 10;
      end
      for (int t = 0; t < n; t++) begin
         if (!shown && (t + 1 < n) && digits[n - 1 - t] == 4'd0) begin
            code = fwdf_pkg::CH_SPACE;
         end else begin
            shown = 1'b1;
            code  = fwdf_pkg::CH_ZERO + 6'(digits[n - 1 - t]);
         end
         line[k] = '{char_code: code, column: 8'(col + pitch * t), row: row, last: 1'b0};
         k++;
      end
      if (k > 0) line[k - 1].last = 1'b1;
      for (int i = 0; i < k; i++) expected_chars.push_back(line[i]);
   endtask

   task automatic check_field(input string field_name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected character, expected none, actual code %0d col %0d",
                     $time, rsp_char_code, rsp_column);
            error_count++;
         end else begin
            oldest_char = expected_chars.pop_front();
            check_field("char_code", oldest_char.char_code, rsp_char_code);
            check_field("column", oldest_char.column, rsp_column);
            check_field("row", oldest_char.row, rsp_row);
            check_field("last", oldest_char.last, rsp_last);
         end
      end
   end

   // one start beat, start left high for a possible back-to-back beat
   task automatic send_number(input logic [31:0] value, input logic [3:0] count,
                              input logic [7:0] col, input logic [5:0] row);
      start            <= 1'b1;
      req_value        <= value;
      req_digit_count  <= count;
      req_start_column <= col;
      req_start_row    <= row;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_number(value, count, col, row);
   endtask

   task automatic drain_block();
      start <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_font(input logic font_sel);
      csr_write_enable <= 1'b1;
      csr_write_data   <= font_sel;
      @(posedge clock);
      font_large       = font_sel;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 1'($urandom_range(1));
   endtask

   function automatic logic [31:0] random_value();
      logic [31:0] pow10;
      pow10 = 32'd1;
      unique case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(999);
         2: return 32'd0 - $urandom_range(1, 999);
         3: begin
            repeat ($urandom_range(9)) pow10 = pow10 * 32'd10;
            return $urandom_range(1) ? pow10 : 32'd0 - pow10;
         end
         4: begin
            unique case ($urandom_range(3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'd0;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return $urandom | 32'h8000_0000;
      endcase
   endfunction

   function automatic logic [3:0] random_count();
      unique case ($urandom_range(9))
         0: return 4'd0;
         1: return 4'($urandom_range(11, 15));
         default: return 4'($urandom_range(1, 10));
      endcase
   endfunction

   task automatic test_small_font_directed();
      write_font(1'b0);
      send_number(32'd0, 4'd1, 8'd0, 6'd0);
      send_number(32'd0, 4'd10, 8'd10, 6'd5);
      send_number(32'h7fff_ffff, 4'd10, 8'd0, 6'd63);
      send_number(32'h8000_0000, 4'd10, 8'd250, 6'd0);
      send_number(32'hffff_ffff, 4'd1, 8'd255, 6'd42);
      send_number(32'd1234567, 4'd3, 8'd100, 6'd21);
      send_number(32'd1000000000, 4'd10, 8'd230, 6'd10);
      send_number(32'd1000, 4'd3, 8'd64, 6'd1);
      send_number(32'd42, 4'd15, 8'd16, 6'd2);
      send_number(32'd0, 4'd0, 8'd20, 6'd3);
      send_number(32'hffff_fffb, 4'd0, 8'd30, 6'd4);
      send_number(32'd5, 4'd0, 8'd40, 6'd5);
      send_number(32'd305, 4'd11, 8'd128, 6'd32);
      drain_block();
   endtask

   task automatic test_large_font_directed();
      write_font(1'b1);
      send_number(32'h8000_0000, 4'd10, 8'd200, 6'd63);
      send_number(32'hffff_fff9, 4'd4, 8'd255, 6'd7);
      send_number(32'd99, 4'd0, 8'd3, 6'd8);
      send_number(32'hffff_ff9d, 4'd0, 8'd250, 6'd9);
      send_number(32'h7fff_ffff, 4'd15, 8'd170, 6'd0);
      send_number(32'd0, 4'd1, 8'd255, 6'd63);
      drain_block();
   endtask

   task automatic test_random_numbers(input int items, input int idle_pct,
                                      input logic font_sel);
      write_font(font_sel);
      repeat (items) begin
         while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clock);
         end
         send_number(random_value(), random_count(), 8'($urandom), 6'($urandom));
      end
      drain_block();
   endtask

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_value        <= '0;
      req_digit_count  <= '0;
      req_start_column <= '0;
      req_start_row    <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 1'b0;
      font_large       = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_small_font_directed();
      test_large_font_directed();
      test_random_numbers(150, 13, 1'b0);
      test_random_numbers(150, 83, 1'b1);
      test_random_numbers(150, 0, 1'($urandom_range(1)));

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/fwdf_pkg.sv
src/fwdf_sequencer.sv
src/fwdf_datapath.sv
src/fixed_width_decimal_formatter_unit.sv
tb/fixed_width_decimal_formatter_unit_test.sv
